/* hdl/tidrt_pkg.sv */
// Shared constants and types for the tunnel id remap table.
`default_nettype none

package tidrt_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned ID_W        = 32;
  localparam int unsigned ENTRY_W     = 2 * ID_W;

  typedef enum logic [1:0] {
    REQ_LOOKUP  = 2'd0,
    REQ_REVERSE = 2'd1,
    REQ_DELETE  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    STAT_FOUND     = 3'd0,
    STAT_ALLOC     = 3'd1,
    STAT_NOTFOUND  = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_ZERO      = 3'd4,
    STAT_EXHAUSTED = 3'd5
  } status_e;

endpackage

`default_nettype wire

/* hdl/tidrt_req_if.sv */
// Request channel: request type and tunnel id.
`default_nettype none

interface tidrt_req_if;
  import tidrt_pkg::*;

  logic            valid;
  logic            ready;
  logic [1:0]      req_type;
  logic [ID_W-1:0] tunnel_id;

  modport source (output valid, output req_type, output tunnel_id, input ready);
  modport sink   (input valid, input req_type, input tunnel_id, output ready);
endinterface

`default_nettype wire

/* hdl/tidrt_rsp_if.sv */
// Response channel: mapped id and status.
`default_nettype none

interface tidrt_rsp_if;
  import tidrt_pkg::*;

  logic            valid;
  logic            ready;
  logic [ID_W-1:0] mapped_id;
  logic [2:0]      status;

  modport source (output valid, output mapped_id, output status, input ready);
  modport sink   (input valid, input mapped_id, input status, output ready);
endinterface

`default_nettype wire

/* hdl/tidrt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module tidrt_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hdl/tunnel_id_remap_table_unit.sv */
// Tunnel id remap table: top level with scan sequencer, valid marks and id pool.
//
// Each request is served in steps: it is accepted, one RAM read per slot is
// issued through the single read port of the id table, the last read data
// arrives, and then the answer is given and written back. Requests with a zero
// id or an unused request code are accepted and then answered with no scan.
// The next item is taken as soon as the answer sits in the output register,
// whether or not the sink has taken it yet. Valid marks are flops cleared at
// reset, so no clearing pass is needed.
`default_nettype none

module tunnel_id_remap_table_unit
  import tidrt_pkg::*;
(
  input wire logic   clk_i,
  input wire logic   rst_ni,
  tidrt_req_if.sink  req_i,
  tidrt_rsp_if.source rsp_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  state_e           state_q;
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [ID_W-1:0]  last_q;

  // request being served
  req_e             req_q;
  logic [ID_W-1:0]  id_q;
  logic             rej_q;
  status_e          rej_st_q;

  // scan bookkeeping
  logic [IDX_W-1:0] addr_q;
  logic             issue_q;
  logic             rd_pend_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             hit_q;
  logic [IDX_W-1:0] hit_idx_q;
  logic [ID_W-1:0]  hit_data_q;
  logic             free_q;
  logic [IDX_W-1:0] free_idx_q;

  // output register
  logic             out_vld_q;
  logic [ID_W-1:0]  out_mapped_q;
  status_e          out_st_q;

  logic             req_fire;
  logic             resp_go;
  logic             ram_we;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ID_W-1:0]  rd_key;
  logic [ID_W-1:0]  rd_other;
  logic             rd_match;
  logic             rd_free;
  logic [ID_W-1:0]  last_inc;

  assign req_i.ready   = (state_q == ST_IDLE);
  assign req_fire      = req_i.valid && req_i.ready;
  assign resp_go       = (state_q == ST_RESP) && (!out_vld_q || rsp_o.ready);
  assign last_inc      = last_q + ID_W'(1);

  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.mapped_id = out_mapped_q;
  assign rsp_o.status    = out_st_q;

  // entries hold {original, replacement}
  always_comb begin
    if (req_q == REQ_REVERSE) begin
      rd_key   = ram_rdata[ID_W-1:0];
      rd_other = ram_rdata[ENTRY_W-1:ID_W];
    end else begin
      rd_key   = ram_rdata[ENTRY_W-1:ID_W];
      rd_other = ram_rdata[ID_W-1:0];
    end
    rd_match = rd_pend_q && valid_q[rd_idx_q] && (rd_key == id_q);
    rd_free  = rd_pend_q && !valid_q[rd_idx_q];
  end

  assign ram_we = resp_go && !rej_q && (req_q == REQ_LOOKUP) && !hit_q && free_q &&
                  (last_q != '1);

  tidrt_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_idx_q),
    .wdata_i ({id_q, last_inc}),
    .re_i    (issue_q),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= '0;
      last_q    <= '0;
      issue_q   <= 1'b0;
      rd_pend_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (resp_go) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req_fire) begin
            req_q      <= req_e'(req_i.req_type);
            id_q       <= req_i.tunnel_id;
            addr_q     <= '0;
            hit_q      <= 1'b0;
            free_q     <= 1'b0;
            rd_pend_q  <= 1'b0;
            rej_q      <= 1'b0;
            if (req_i.req_type != REQ_LOOKUP && req_i.req_type != REQ_REVERSE &&
                req_i.req_type != REQ_DELETE) begin
              rej_q    <= 1'b1;
              rej_st_q <= STAT_NOTFOUND;
              state_q  <= ST_RESP;
            end else if (req_i.tunnel_id == '0) begin
              rej_q    <= 1'b1;
              rej_st_q <= STAT_ZERO;
              state_q  <= ST_RESP;
            end else begin
              issue_q  <= 1'b1;
              state_q  <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // issue_q is already low when the last slot's data arrives
          rd_pend_q <= issue_q;
          rd_idx_q  <= addr_q;
          if (issue_q) begin
            addr_q <= addr_q + IDX_W'(1);
            if (addr_q == IDX_W'(TABLE_DEPTH - 1)) begin
              issue_q <= 1'b0;
            end
          end
          if (rd_match && !hit_q) begin
            hit_q      <= 1'b1;
            hit_idx_q  <= rd_idx_q;
            hit_data_q <= rd_other;
          end
          if (rd_free && !free_q) begin
            free_q     <= 1'b1;
            free_idx_q <= rd_idx_q;
          end
          // last slot's data is in this cycle
          if (rd_pend_q && rd_idx_q == IDX_W'(TABLE_DEPTH - 1)) begin
            state_q   <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (resp_go) begin
            state_q      <= ST_IDLE;
            if (rej_q) begin
              out_st_q     <= rej_st_q;
              out_mapped_q <= '0;
            end else if (hit_q) begin
              out_st_q     <= STAT_FOUND;
              out_mapped_q <= hit_data_q;
              if (req_q == REQ_DELETE) begin
                valid_q[hit_idx_q] <= 1'b0;
              end
            end else if (req_q != REQ_LOOKUP) begin
              out_st_q     <= STAT_NOTFOUND;
              out_mapped_q <= '0;
            end else if (!free_q) begin
              out_st_q     <= STAT_FULL;
              out_mapped_q <= '0;
            end else if (last_q == '1) begin
              out_st_q     <= STAT_EXHAUSTED;
              out_mapped_q <= '0;
            end else begin
              out_st_q            <= STAT_ALLOC;
              out_mapped_q        <= last_inc;
              last_q              <= last_inc;
              valid_q[free_idx_q] <= 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
